/* rtl/wav_header_parser_top_defines.svh */
// assertion macros shared by the wav header parser modules
`ifndef WAV_HEADER_PARSER_TOP_DEFINES_SVH
`define WAV_HEADER_PARSER_TOP_DEFINES_SVH

// plain property, checked on every clock edge outside reset
`define WAVHP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// property that must hold in the cycle after its trigger
`define WAVHP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/wavhp_pkg.sv */
// shared types, constants and helper functions for the wav header parser
`timescale 1ns / 1ps

package wavhp_pkg;

    // header geometry
    localparam int unsigned HDR_BYTES   = 36;
    localparam int unsigned IDX_W       = 6;
    localparam logic [IDX_W-1:0] LAST_IDX = 6'd35;
    localparam logic [IDX_W-1:0] IDLE_IDX = 6'd36;

    // field offsets in the header
    localparam logic [IDX_W-1:0] OFS_RIFF_LEN = 6'd4;
    localparam logic [IDX_W-1:0] OFS_WAVE_ID  = 6'd8;
    localparam logic [IDX_W-1:0] OFS_FMT_ID   = 6'd12;
    localparam logic [IDX_W-1:0] OFS_FMT_LEN  = 6'd16;
    localparam logic [IDX_W-1:0] OFS_SUBFMT   = 6'd20;
    localparam logic [IDX_W-1:0] OFS_CHANS    = 6'd22;
    localparam logic [IDX_W-1:0] OFS_RATE     = 6'd24;
    localparam logic [IDX_W-1:0] OFS_BRATE    = 6'd28;
    localparam logic [IDX_W-1:0] OFS_ALIGN    = 6'd32;
    localparam logic [IDX_W-1:0] OFS_BITS     = 6'd34;

    // id flag bit positions
    localparam int unsigned ID_RIFF = 0;
    localparam int unsigned ID_WAVE = 1;
    localparam int unsigned ID_FMT  = 2;

    // format values
    localparam logic [15:0] FMT_PCM   = 16'h0001;
    localparam logic [15:0] FMT_FLOAT = 16'h0003;
    localparam logic [31:0] RIFF_HDR_EXTRA = 32'd8;

    // status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_NO_RIFF     = 3'd1;
    localparam logic [2:0] ST_NO_WAVE     = 3'd2;
    localparam logic [2:0] ST_NO_FMT      = 3'd3;
    localparam logic [2:0] ST_BAD_SUBFMT  = 3'd4;
    localparam logic [2:0] ST_BAD_CHANS   = 3'd5;
    localparam logic [2:0] ST_BAD_PCM     = 3'd6;
    localparam logic [2:0] ST_BAD_FLOAT   = 3'd7;

    // stream widths
    localparam int unsigned S_TDATA_W  = 8;
    localparam int unsigned M_FIELDS_W = 148;
    localparam int unsigned M_TDATA_W  = 152;

    // captured header fields handed from capture to check
    typedef struct packed {
        logic [2:0]  id_flags;
        logic [31:0] riff_length;
        logic [31:0] fmt_length;
        logic [15:0] sub_format;
        logic [15:0] channels;
        logic [31:0] rate;
        logic [31:0] bytes_rate;
        logic [15:0] align;
        logic [15:0] bits;
    } hdr_fields_t;

    // expected id byte at header offsets 0..15, offsets 4..7 are unused
    function automatic logic [7:0] id_byte(input logic [3:0] ofs);
        logic [7:0] b;
        unique case (ofs)
            4'd0:    b = 8'h52;  // R
            4'd1:    b = 8'h49;  // I
            4'd2:    b = 8'h46;  // F
            4'd3:    b = 8'h46;  // F
            4'd8:    b = 8'h57;  // W
            4'd9:    b = 8'h41;  // A
            4'd10:   b = 8'h56;  // V
            4'd11:   b = 8'h45;  // E
            4'd12:   b = 8'h66;  // f
            4'd13:   b = 8'h6d;  // m
            4'd14:   b = 8'h74;  // t
            4'd15:   b = 8'h20;  // space
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

/* rtl/wavhp_capture.sv */
// byte counter, id checks and little-endian field capture
`timescale 1ns / 1ps
`include "wav_header_parser_top_defines.svh"

module wavhp_capture (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          byte_accept,
    input  logic [7:0]                    header_byte,
    input  logic                          start_req,
    output logic                          at_last_byte,
    output logic                          done,
    output wavhp_pkg::hdr_fields_t        fields
);

    logic [wavhp_pkg::IDX_W-1:0] byte_index_reg;
    logic [wavhp_pkg::IDX_W-1:0] cur_idx;
    logic                        in_header;
    logic                        done_reg;
    wavhp_pkg::hdr_fields_t      fields_reg;
    wavhp_pkg::hdr_fields_t      fields_next;
    logic [2:0]                  id_base;
    logic                        id_mismatch;

    // effective index of this request: a start forces byte zero
    assign cur_idx      = start_req ? '0 : byte_index_reg;
    assign in_header    = (cur_idx < wavhp_pkg::IDLE_IDX);
    assign id_base      = start_req ? 3'b111 : fields_reg.id_flags;
    assign id_mismatch  = (header_byte != wavhp_pkg::id_byte(cur_idx[3:0]));
    assign at_last_byte = (byte_index_reg == wavhp_pkg::LAST_IDX);

    // field update for the current byte
    always_comb begin
        fields_next          = fields_reg;
        fields_next.id_flags = id_base;
        if (in_header) begin
            priority if (cur_idx < wavhp_pkg::OFS_RIFF_LEN) begin
                if (id_mismatch) fields_next.id_flags[wavhp_pkg::ID_RIFF] = 1'b0;
            end else if (cur_idx < wavhp_pkg::OFS_WAVE_ID) begin
                fields_next.riff_length[cur_idx[1:0]*8 +: 8] = header_byte;
            end else if (cur_idx < wavhp_pkg::OFS_FMT_ID) begin
                if (id_mismatch) fields_next.id_flags[wavhp_pkg::ID_WAVE] = 1'b0;
            end else if (cur_idx < wavhp_pkg::OFS_FMT_LEN) begin
                if (id_mismatch) fields_next.id_flags[wavhp_pkg::ID_FMT] = 1'b0;
            end else if (cur_idx < wavhp_pkg::OFS_SUBFMT) begin
                fields_next.fmt_length[cur_idx[1:0]*8 +: 8] = header_byte;
            end else if (cur_idx < wavhp_pkg::OFS_CHANS) begin
                fields_next.sub_format[cur_idx[0]*8 +: 8] = header_byte;
            end else if (cur_idx < wavhp_pkg::OFS_RATE) begin
                fields_next.channels[cur_idx[0]*8 +: 8] = header_byte;
            end else if (cur_idx < wavhp_pkg::OFS_BRATE) begin
                fields_next.rate[cur_idx[1:0]*8 +: 8] = header_byte;
            end else if (cur_idx < wavhp_pkg::OFS_ALIGN) begin
                fields_next.bytes_rate[cur_idx[1:0]*8 +: 8] = header_byte;
            end else if (cur_idx < wavhp_pkg::OFS_BITS) begin
                fields_next.align[cur_idx[0]*8 +: 8] = header_byte;
            end else begin
                fields_next.bits[cur_idx[0]*8 +: 8] = header_byte;
            end
        end
    end

    // counter, done pulse and field registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_index_reg <= wavhp_pkg::IDLE_IDX;
            done_reg       <= 1'b0;
            fields_reg     <= '{id_flags: 3'b111, default: '0};
        end else begin
            done_reg <= byte_accept && in_header && (cur_idx == wavhp_pkg::LAST_IDX);
            if (byte_accept) begin
                fields_reg <= fields_next;
                if (in_header) begin
                    byte_index_reg <= cur_idx + 1'b1;
                end else begin
                    byte_index_reg <= cur_idx;
                end
            end
        end
    end

    assign done   = done_reg;
    assign fields = fields_reg;

    // checks
    `WAVHP_ASSERT(a_idx_range, aclk, aresetn, byte_index_reg <= wavhp_pkg::IDLE_IDX, "byte index out of range")
    `WAVHP_ASSERT_NEXT(a_done_single, aclk, aresetn, done_reg, !done_reg, "done lasted two cycles")
    `WAVHP_ASSERT_NEXT(a_done_idle, aclk, aresetn, done_reg && !byte_accept, byte_index_reg == wavhp_pkg::IDLE_IDX, "counter not idle after last byte")

endmodule

/* rtl/wavhp_check.sv */
// header checks, length compare and result register
`timescale 1ns / 1ps
`include "wav_header_parser_top_defines.svh"

module wavhp_check (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [31:0]                      cfg_wr_data,
    input  logic                             done,
    input  wavhp_pkg::hdr_fields_t           fields,
    output logic                             out_busy,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [wavhp_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    output logic                             m_axis_tuser
);

    logic [31:0]                       file_size_reg;
    logic                              out_valid_reg;
    logic [wavhp_pkg::M_FIELDS_W-1:0]  out_data_reg;
    logic                              out_float_reg;
    logic [2:0]                        status;
    logic                              is_float;
    logic                              is_pcm;
    logic                              chans_ok;
    logic                              pcm_bits_ok;
    logic                              mismatch;
    logic [31:0]                       riff_total;

    // field checks in header order
    assign is_pcm      = (fields.sub_format == wavhp_pkg::FMT_PCM);
    assign is_float    = (fields.sub_format == wavhp_pkg::FMT_FLOAT);
    assign chans_ok    = (fields.channels == 16'd1) || (fields.channels == 16'd2);
    assign pcm_bits_ok = (fields.bits == 16'd8) || (fields.bits == 16'd16) ||
                         (fields.bits == 16'd24);
    assign riff_total  = fields.riff_length + wavhp_pkg::RIFF_HDR_EXTRA;
    assign mismatch    = (riff_total != file_size_reg);

    // first failing check sets the status
    always_comb begin
        priority if (!fields.id_flags[wavhp_pkg::ID_RIFF]) status = wavhp_pkg::ST_NO_RIFF;
        else if (!fields.id_flags[wavhp_pkg::ID_WAVE])     status = wavhp_pkg::ST_NO_WAVE;
        else if (!fields.id_flags[wavhp_pkg::ID_FMT])      status = wavhp_pkg::ST_NO_FMT;
        else if (!is_pcm && !is_float)                     status = wavhp_pkg::ST_BAD_SUBFMT;
        else if (!chans_ok)                                status = wavhp_pkg::ST_BAD_CHANS;
        else if (is_pcm && !pcm_bits_ok)                   status = wavhp_pkg::ST_BAD_PCM;
        else if (is_float && (fields.bits != 16'd32))      status = wavhp_pkg::ST_BAD_FLOAT;
        else                                               status = wavhp_pkg::ST_OK;
    end

    // file size register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            file_size_reg <= '0;
        end else if (cfg_wr_en) begin
            file_size_reg <= cfg_wr_data;
        end
    end

    // result valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (done) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (done) begin
            out_float_reg <= is_float;
            out_data_reg  <= {mismatch, fields.fmt_length, fields.bits, fields.align,
                              fields.bytes_rate, fields.rate, fields.channels, status};
        end
    end

    assign out_busy      = out_valid_reg && !m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(wavhp_pkg::M_TDATA_W - wavhp_pkg::M_FIELDS_W){1'b0}},
                            out_data_reg};
    assign m_axis_tuser  = out_float_reg;

    // checks
    `WAVHP_ASSERT(a_no_overwrite, aclk, aresetn, !(done && out_valid_reg), "result overwritten")
    `WAVHP_ASSERT_NEXT(a_done_shows, aclk, aresetn, done, out_valid_reg, "result not shown after done")

endmodule

/* rtl/wav_header_parser_top.sv */
// Top level of the wav header parser: one header byte per request, one result per header.
// The 36th accepted header byte raises the done pulse, which loads the result register and sets its valid.
// Throughput: one byte per cycle; a byte offered while the counter sits at the 36th position,
// start flag or not, waits while an earlier result still sits untaken in the result register.
// Reset (aresetn low, synchronous) idles the byte counter until a start, clears the
// result register valid and sets the file size to zero.
`timescale 1ns / 1ps

module wav_header_parser_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration: file size in bytes
    input  logic                             cfg_wr_en,
    input  logic [31:0]                      cfg_wr_data,
    // input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [wavhp_pkg::S_TDATA_W-1:0]  s_axis_tdata,  // [7:0] header_byte
    input  logic                             s_axis_tuser,  // [0] start_req
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [2:0] status, [18:3] channel_count, [50:19] sample_rate, [82:51] byte_rate,
    // [98:83] block_align, [114:99] sample_bits, [146:115] format_length,
    // [147] length_mismatch, [151:148] zero
    output logic [wavhp_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    output logic                             m_axis_tuser   // [0] is_float
);

    logic                   byte_accept;
    logic                   at_last_byte;
    logic                   done;
    logic                   out_busy;
    wavhp_pkg::hdr_fields_t fields;

    // hold the last header byte while the previous result is still pending
    assign s_axis_tready = !(at_last_byte && out_busy);
    assign byte_accept   = s_axis_tvalid && s_axis_tready;

    // byte capture
    wavhp_capture u_capture (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .byte_accept  (byte_accept),
        .header_byte  (s_axis_tdata),
        .start_req    (s_axis_tuser),
        .at_last_byte (at_last_byte),
        .done         (done),
        .fields       (fields)
    );

    // checks and result register
    wavhp_check u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .done          (done),
        .fields        (fields),
        .out_busy      (out_busy),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

/* bench/wav_header_parser_check.sv */
// checker for the wav header parser: predicts parsed header results and compares them
`timescale 1ns / 1ps

module wav_header_parser_check (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [31:0]                     cfg_wr_data,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // [7:0] header_byte
    input  logic                            s_axis_tuser,  // [0] start_req
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [wavhp_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input  logic                            m_axis_tuser,  // [0] is_float
    output int                              mismatches,
    output int                              headers_outstanding
);

    typedef struct packed {
        logic [2:0]  status;
        logic        is_float;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [31:0] byte_rate;
        logic [15:0] block_align;
        logic [15:0] sample_bits;
        logic [31:0] format_length;
        logic        length_mismatch;
    } hdr_result_t;

    localparam logic [31:0] TAG_RIFF = "RIFF";
    localparam logic [31:0] TAG_WAVE = "WAVE";
    localparam logic [31:0] TAG_FMT  = "fmt ";

    hdr_result_t parsed_headers_q [$];

    // shadow of the parser state
    int unsigned hdr_pos;
    logic [2:0]  tags_ok;
    logic [31:0] file_size_q;
    logic [31:0] riff_len;
    logic [31:0] fmt_len;
    logic [15:0] subfmt;
    logic [15:0] chans;
    logic [31:0] rate;
    logic [31:0] brate;
    logic [15:0] align;
    logic [15:0] bits;
    int          err_cnt = 0;

    // byte expected at an id position of the first sixteen
    function automatic logic [7:0] expected_tag(input int unsigned pos);
        logic [127:0] tags;
        tags = {TAG_RIFF, 32'h0, TAG_WAVE, TAG_FMT};
        return tags[127 - 8 * pos -: 8];
    endfunction

    // first failing check wins
    function automatic logic [2:0] judge_header();
        if (!tags_ok[wavhp_pkg::ID_RIFF]) return wavhp_pkg::ST_NO_RIFF;
        if (!tags_ok[wavhp_pkg::ID_WAVE]) return wavhp_pkg::ST_NO_WAVE;
        if (!tags_ok[wavhp_pkg::ID_FMT]) return wavhp_pkg::ST_NO_FMT;
        if (subfmt != wavhp_pkg::FMT_PCM && subfmt != wavhp_pkg::FMT_FLOAT)
            return wavhp_pkg::ST_BAD_SUBFMT;
        if (chans != 16'd1 && chans != 16'd2) return wavhp_pkg::ST_BAD_CHANS;
        if (subfmt == wavhp_pkg::FMT_PCM &&
            bits != 16'd8 && bits != 16'd16 && bits != 16'd24)
            return wavhp_pkg::ST_BAD_PCM;
        if (subfmt == wavhp_pkg::FMT_FLOAT && bits != 16'd32) return wavhp_pkg::ST_BAD_FLOAT;
        return wavhp_pkg::ST_OK;
    endfunction

    // absorb one accepted header byte, queue a result on the last one
    task automatic parse_byte(input logic [7:0] b, input logic st);
        hdr_result_t r;
        if (st) begin
            hdr_pos = 0;
            tags_ok = '1;
        end
        if (hdr_pos < wavhp_pkg::HDR_BYTES) begin
            if (hdr_pos < 4) begin
                if (b != expected_tag(hdr_pos)) tags_ok[wavhp_pkg::ID_RIFF] = 1'b0;
            end else if (hdr_pos < 8) begin
                riff_len[8 * (hdr_pos - 4) +: 8] = b;
            end else if (hdr_pos < 12) begin
                if (b != expected_tag(hdr_pos)) tags_ok[wavhp_pkg::ID_WAVE] = 1'b0;
            end else if (hdr_pos < 16) begin
                if (b != expected_tag(hdr_pos)) tags_ok[wavhp_pkg::ID_FMT] = 1'b0;
            end else if (hdr_pos < 20) begin
                fmt_len[8 * (hdr_pos - 16) +: 8] = b;
            end else if (hdr_pos < 22) begin
                subfmt[8 * (hdr_pos - 20) +: 8] = b;
            end else if (hdr_pos < 24) begin
                chans[8 * (hdr_pos - 22) +: 8] = b;
            end else if (hdr_pos < 28) begin
                rate[8 * (hdr_pos - 24) +: 8] = b;
            end else if (hdr_pos < 32) begin
                brate[8 * (hdr_pos - 28) +: 8] = b;
            end else if (hdr_pos < 34) begin
                align[8 * (hdr_pos - 32) +: 8] = b;
            end else begin
                bits[8 * (hdr_pos - 34) +: 8] = b;
            end
            if (hdr_pos == wavhp_pkg::HDR_BYTES - 1) begin
                r.status          = judge_header();
                r.is_float        = (subfmt == wavhp_pkg::FMT_FLOAT);
                r.channel_count   = chans;
                r.sample_rate     = rate;
                r.byte_rate       = brate;
                r.block_align     = align;
                r.sample_bits     = bits;
                r.format_length   = fmt_len;
                r.length_mismatch = ((riff_len + wavhp_pkg::RIFF_HDR_EXTRA) != file_size_q);
                parsed_headers_q.push_back(r);
            end
            hdr_pos++;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            err_cnt++;
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endtask

    // watch both channels and the register write
    always @(posedge aclk) begin
        hdr_result_t want;
        if (!aresetn) begin
            hdr_pos     = wavhp_pkg::HDR_BYTES;
            tags_ok     = '1;
            file_size_q = '0;
            riff_len    = '0;
            fmt_len     = '0;
            subfmt      = '0;
            chans       = '0;
            rate        = '0;
            brate       = '0;
            align       = '0;
            bits        = '0;
            parsed_headers_q.delete();
        end else begin
            if (cfg_wr_en) file_size_q = cfg_wr_data;
            if (s_axis_tvalid && s_axis_tready) parse_byte(s_axis_tdata, s_axis_tuser);
            if (m_axis_tvalid && m_axis_tready) begin
                if (parsed_headers_q.size() == 0) begin
                    err_cnt++;
                    $error("result request with no header pending");
                end else begin
                    want = parsed_headers_q.pop_front();
                    check_field("status", want.status, m_axis_tdata[2:0]);
                    check_field("is_float", want.is_float, m_axis_tuser);
                    check_field("channel_count", want.channel_count, m_axis_tdata[18:3]);
                    check_field("sample_rate", want.sample_rate, m_axis_tdata[50:19]);
                    check_field("byte_rate", want.byte_rate, m_axis_tdata[82:51]);
                    check_field("block_align", want.block_align, m_axis_tdata[98:83]);
                    check_field("sample_bits", want.sample_bits, m_axis_tdata[114:99]);
                    check_field("format_length", want.format_length, m_axis_tdata[146:115]);
                    check_field("length_mismatch", want.length_mismatch, m_axis_tdata[147]);
                end
            end
        end
        headers_outstanding <= parsed_headers_q.size();
        mismatches          <= err_cnt;
    end

endmodule

/* bench/wav_header_parser_top_test.sv */
// testbench top: drives header byte streams and file size writes, gives the verdict
`timescale 1ns / 1ps

module wav_header_parser_top_test;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned BYTE_TARGET  = 1250;
    localparam logic [31:0] TAG_RIFF = "RIFF";
    localparam logic [31:0] TAG_WAVE = "WAVE";
    localparam logic [31:0] TAG_FMT  = "fmt ";

    logic                             aclk = 1'b0;
    logic                             aresetn;
    logic                             cfg_wr_en;
    logic [31:0]                      cfg_wr_data;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [7:0]                       s_axis_tdata;   // [7:0] header_byte
    logic                             s_axis_tuser;   // [0] start_req
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [wavhp_pkg::M_TDATA_W-1:0]  m_axis_tdata;   // status .. length_mismatch
    logic                             m_axis_tuser;   // [0] is_float

    int                    mismatches;
    int                    outstanding;
    int unsigned           cycle_cnt = 0;
    int unsigned           bytes_sent = 0;
    bit                    send_calm = 1'b0;
    bit                    recv_calm = 1'b0;
    logic [31:0]           file_size_now = '0;
    logic [7:0]            hdr_buf [0:wavhp_pkg::HDR_BYTES-1];

    wav_header_parser_top i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    wav_header_parser_check i_check (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_data         (cfg_wr_data),
        .s_axis_tvalid       (s_axis_tvalid),
        .s_axis_tready       (s_axis_tready),
        .s_axis_tdata        (s_axis_tdata),
        .s_axis_tuser        (s_axis_tuser),
        .m_axis_tvalid       (m_axis_tvalid),
        .m_axis_tready       (m_axis_tready),
        .m_axis_tdata        (m_axis_tdata),
        .m_axis_tuser        (m_axis_tuser),
        .mismatches          (mismatches),
        .headers_outstanding (outstanding)
    );

    always #5 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: random stalls with calm stretches
    initial begin
        int gap;
        m_axis_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if ($urandom_range(0, 15) == 0) recv_calm = !recv_calm;
            gap = recv_calm ? 0 : $urandom_range(0, 19);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
        end
    end

    // one byte request, with a random gap ahead of it
    task automatic send_byte(input logic [7:0] b, input logic st);
        int gap;
        gap = send_calm ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= st;
        do @(posedge aclk); while (!s_axis_tready);
        bytes_sent++;
    endtask

    // stop sending and wait until every result is taken
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_file_size(input logic [31:0] v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        file_size_now = v;
    endtask

    task automatic fill_header(input logic [15:0] fmt, input logic [15:0] chans,
                               input logic [15:0] bits, input logic [31:0] riff,
                               input logic [31:0] flen, input logic [31:0] rate,
                               input logic [31:0] brate, input logic [15:0] align);
        for (int k = 0; k < 4; k++) begin
            hdr_buf[k]      = TAG_RIFF[31 - 8 * k -: 8];
            hdr_buf[4 + k]  = riff[8 * k +: 8];
            hdr_buf[8 + k]  = TAG_WAVE[31 - 8 * k -: 8];
            hdr_buf[12 + k] = TAG_FMT[31 - 8 * k -: 8];
            hdr_buf[16 + k] = flen[8 * k +: 8];
            hdr_buf[24 + k] = rate[8 * k +: 8];
            hdr_buf[28 + k] = brate[8 * k +: 8];
        end
        for (int k = 0; k < 2; k++) begin
            hdr_buf[20 + k] = fmt[8 * k +: 8];
            hdr_buf[22 + k] = chans[8 * k +: 8];
            hdr_buf[32 + k] = align[8 * k +: 8];
            hdr_buf[34 + k] = bits[8 * k +: 8];
        end
    endtask

    // plain 16 bit stereo pcm header whose riff length fits a 44 byte file
    task automatic base_header();
        fill_header(wavhp_pkg::FMT_PCM, 16'd2, 16'd16, 32'd36, 32'd16, 32'd44100,
                    32'd176400, 16'd4);
    endtask

    // send the first n_bytes of the buffer, start flag on byte zero
    task automatic send_header(input int unsigned n_bytes);
        for (int k = 0; k < n_bytes; k++)
            send_byte(hdr_buf[k], k == 0);
    endtask

    task automatic send_noise(input int unsigned n_bytes, input bit with_starts);
        for (int k = 0; k < n_bytes; k++)
            send_byte(8'($urandom()), with_starts && ($urandom_range(0, 7) == 0));
    endtask

    // well-formed header with random content
    task automatic random_good();
        logic [15:0] fmt;
        logic [15:0] bits;
        logic [31:0] riff;
        logic [31:0] flen;
        fmt = $urandom_range(0, 1) ? wavhp_pkg::FMT_FLOAT : wavhp_pkg::FMT_PCM;
        case ($urandom_range(0, 2))
            0:       bits = 16'd8;
            1:       bits = 16'd16;
            default: bits = 16'd24;
        endcase
        if (fmt == wavhp_pkg::FMT_FLOAT) bits = 16'd32;
        riff = $urandom_range(0, 1) ? file_size_now - wavhp_pkg::RIFF_HDR_EXTRA
                                    : 32'($urandom());
        flen = ($urandom_range(0, 3) == 0) ? 32'($urandom()) : 32'd16;
        fill_header(fmt, 16'($urandom_range(1, 2)), bits, riff, flen, 32'($urandom()),
                    32'($urandom()), 16'($urandom()));
    endtask

    // break one part of the buffered header
    task automatic spoil_header();
        int unsigned p;
        case ($urandom_range(0, 4))
            0: begin
                p = $urandom_range(0, 11);
                if (p >= 4) p = p + 4;
                hdr_buf[p] = hdr_buf[p] ^ 8'($urandom_range(1, 255));
            end
            1: begin
                hdr_buf[20] = 8'($urandom());
                hdr_buf[21] = $urandom_range(0, 1) ? 8'($urandom()) : 8'h00;
            end
            2: begin
                hdr_buf[22] = 8'($urandom_range(0, 4));
                hdr_buf[23] = $urandom_range(0, 3) ? 8'h00 : 8'($urandom());
            end
            3: begin
                hdr_buf[34] = 8'($urandom_range(0, 40));
                hdr_buf[35] = $urandom_range(0, 3) ? 8'h00 : 8'($urandom());
            end
            default: hdr_buf[20] = hdr_buf[20] ^ 8'h02;  // swap pcm and float codes
        endcase
    endtask

    // stimulus and verdict
    initial begin
        int unsigned roll;
        int unsigned rounds;
        aresetn       <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // bytes before any start are ignored
        send_noise(4, 1'b0);
        set_file_size(32'd44);

        // good headers, then bytes past the end that give nothing
        base_header();
        send_header(wavhp_pkg::HDR_BYTES);
        send_noise(3, 1'b0);
        fill_header(wavhp_pkg::FMT_FLOAT, 16'd1, 16'd32, 32'd100, 32'd18, 32'd48000,
                    32'd192000, 16'd4);
        send_header(wavhp_pkg::HDR_BYTES);
        fill_header(wavhp_pkg::FMT_PCM, 16'd1, 16'd8, 32'd36, 32'd16, 32'd8000,
                    32'd8000, 16'd1);
        send_header(wavhp_pkg::HDR_BYTES);
        fill_header(wavhp_pkg::FMT_PCM, 16'd2, 16'd24, 32'd36, 32'd16, 32'd96000,
                    32'd576000, 16'd6);
        send_header(wavhp_pkg::HDR_BYTES);

        // each failing check in turn
        base_header();
        hdr_buf[0] = 8'h00;
        send_header(wavhp_pkg::HDR_BYTES);
        base_header();
        hdr_buf[11] = 8'hff;
        send_header(wavhp_pkg::HDR_BYTES);
        base_header();
        hdr_buf[15] = 8'h00;
        send_header(wavhp_pkg::HDR_BYTES);
        base_header();
        hdr_buf[20] = 8'h02;
        send_header(wavhp_pkg::HDR_BYTES);
        base_header();
        hdr_buf[22] = 8'h00;
        send_header(wavhp_pkg::HDR_BYTES);
        base_header();
        hdr_buf[34] = 8'd12;
        send_header(wavhp_pkg::HDR_BYTES);
        fill_header(wavhp_pkg::FMT_FLOAT, 16'd2, 16'd16, 32'd36, 32'd16, 32'd44100,
                    32'd176400, 16'd4);
        send_header(wavhp_pkg::HDR_BYTES);

        // several failures at once: the riff check wins
        base_header();
        hdr_buf[1]  = 8'h00;
        hdr_buf[9]  = 8'h00;
        hdr_buf[22] = 8'h07;
        send_header(wavhp_pkg::HDR_BYTES);

        // field extremes
        fill_header('1, '1, '1, '1, '1, '1, '1, '1);
        send_header(wavhp_pkg::HDR_BYTES);
        fill_header('0, '0, '0, '0, '0, '0, '0, '0);
        send_header(wavhp_pkg::HDR_BYTES);

        // restart one byte short of the end
        base_header();
        send_header(wavhp_pkg::HDR_BYTES - 1);
        send_header(wavhp_pkg::HDR_BYTES);

        // riff length plus eight near the wrap: it wraps around in the first and last case
        set_file_size(32'h0000_0000);
        fill_header(wavhp_pkg::FMT_PCM, 16'd2, 16'd16, 32'hffff_fff8, 32'd16, 32'd1,
                    32'd2, 16'd4);
        send_header(wavhp_pkg::HDR_BYTES);
        set_file_size(32'hffff_ffff);
        fill_header(wavhp_pkg::FMT_PCM, 16'd2, 16'd16, 32'hffff_fff7, 32'd16, 32'd1,
                    32'd2, 16'd4);
        send_header(wavhp_pkg::HDR_BYTES);
        fill_header(wavhp_pkg::FMT_PCM, 16'd2, 16'd16, 32'hffff_ffff, 32'd16, 32'd1,
                    32'd2, 16'd4);
        send_header(wavhp_pkg::HDR_BYTES);

        // random headers: well formed, spoiled, cut short or noise
        rounds = 0;
        while (bytes_sent < BYTE_TARGET) begin
            if (rounds % 8 == 7) begin
                case ($urandom_range(0, 3))
                    0:       set_file_size(32'h0000_0000);
                    1:       set_file_size(32'hffff_ffff);
                    2:       set_file_size(32'($urandom()));
                    default: set_file_size(32'd36 + 32'($urandom_range(0, 4096)));
                endcase
            end
            if ($urandom_range(0, 7) == 0) send_calm = !send_calm;
            roll = $urandom_range(0, 19);
            random_good();
            if (roll < 10) begin
                send_header(wavhp_pkg::HDR_BYTES);
            end else if (roll < 17) begin
                spoil_header();
                if (roll == 16) spoil_header();
                send_header(wavhp_pkg::HDR_BYTES);
            end else if (roll < 19) begin
                send_header($urandom_range(1, wavhp_pkg::HDR_BYTES - 1));
            end else begin
                send_noise($urandom_range(1, 12), 1'b1);
            end
            if ($urandom_range(0, 3) == 0) send_noise($urandom_range(1, 5), 1'b0);
            rounds++;
        end

        drain();
        repeat (4) @(posedge aclk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
